// ----- sv/sel_pkg.sv -----
package sel_pkg;

   // Field widths of the request and response channels
   localparam int CMD_W         = 2;
   localparam int NID_W         = 16;
   localparam int TIME_FIELD_W  = 32;
   localparam int SLOT_W        = 8;
   localparam int PLACED_W      = 8;
   localparam int COUNT_FIELD_W = 9;
   localparam int STATUS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND   = 2'd0,
      CMD_INS_TIME = 2'd1,
      CMD_INS_POS  = 2'd2,
      CMD_READ     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Finished result handed from the sequencer to the response register
   typedef struct packed {
      logic                     fin;
      logic [NID_W-1:0]         read_neuron;
      logic [TIME_FIELD_W-1:0]  read_time;
      logic [PLACED_W-1:0]      placed_at;
      logic [COUNT_FIELD_W-1:0] entry_count;
      logic                     list_sorted;
      status_type               status;
   } res_type;

endpackage

// ----- sv/sel_store.sv -----
module sel_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 48,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sel_cmp.sv -----
module sel_cmp #(
   parameter int W = 32
) (
   input  logic [W-1:0] op_a,
   input  logic [W-1:0] op_b,
   output logic         a_lt_b
);

   // unsigned time compare, shared by scan and inversion bookkeeping
   assign a_lt_b = (op_a < op_b);

endmodule

// ----- sv/sel_ctrl.sv -----
module sel_ctrl #(
   parameter int CAPACITY  = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sel_pkg::CMD_W-1:0]    cmd,
   input  logic [sel_pkg::NID_W-1:0]    neuron_id,
   input  logic [sel_pkg::TIME_FIELD_W-1:0] spike_time,
   input  logic [sel_pkg::SLOT_W-1:0]   slot_index,
   input  logic                         rsp_free,
   output logic                         idle,
   output sel_pkg::res_type             res
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CW      = (CNT_W > sel_pkg::SLOT_W) ? CNT_W : sel_pkg::SLOT_W;
   localparam int ENTRY_W = sel_pkg::NID_W + TIME_BITS;

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_SCAN_RD  = 14'b00000000000010,
      S_SCAN_CMP = 14'b00000000000100,
      S_PREV_RD  = 14'b00000000001000,
      S_PREV_CMP = 14'b00000000010000,
      S_NEXT_RD  = 14'b00000000100000,
      S_NEXT_CMP = 14'b00000001000000,
      S_INV_CMP  = 14'b00000010000000,
      S_SHIFT_RD = 14'b00000100000000,
      S_SHIFT_WR = 14'b00001000000000,
      S_PLACE    = 14'b00010000000000,
      S_RD_RD    = 14'b00100000000000,
      S_RD_DATA  = 14'b01000000000000,
      S_FIN      = 14'b10000000000000
   } state_type;

   state_type                    state_ff, state_in;
   sel_pkg::cmd_type             cmd_ff, cmd_in;
   logic [sel_pkg::NID_W-1:0]    nid_ff, nid_in;
   logic [TIME_BITS-1:0]         tm_ff, tm_in;
   logic [sel_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [IDX_W-1:0]             pos_ff, pos_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [TIME_BITS-1:0]         prev_ff, prev_in;
   logic [TIME_BITS-1:0]         nxt_ff, nxt_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [IDX_W-1:0]             inv_ff, inv_in;
   logic [sel_pkg::NID_W-1:0]    res_nid_ff, res_nid_in;
   logic [TIME_BITS-1:0]         res_time_ff, res_time_in;
   sel_pkg::status_type          status_ff, status_in;
   logic                         fin;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_addr;
   logic [ENTRY_W-1:0]           wr_data;
   logic [IDX_W-1:0]             rd_addr;
   logic [ENTRY_W-1:0]           rd_data;
   logic [TIME_BITS-1:0]         rd_time;
   logic [sel_pkg::NID_W-1:0]    rd_nid;

   logic [TIME_BITS-1:0]         cmp_a, cmp_b;
   logic                         cmp_lt;

   logic [IDX_W-1:0]             count_idx;
   logic [CW-1:0]                slot_cw, count_cw;
   logic                         list_full;

   sel_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ENTRY_W),
      .AW    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sel_cmp #(
      .W (TIME_BITS)
   ) u_cmp (
      .op_a   (cmp_a),
      .op_b   (cmp_b),
      .a_lt_b (cmp_lt)
   );

   assign rd_time   = rd_data[TIME_BITS-1:0];
   assign rd_nid    = rd_data[ENTRY_W-1:TIME_BITS];
   assign count_idx = IDX_W'(count_ff);
   assign slot_cw   = CW'(slot_index);
   assign count_cw  = CW'(count_ff);
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   // shared comparator operand select
   always_comb begin
      cmp_a = rd_time;
      cmp_b = tm_ff;
      unique case (state_ff)
         S_PREV_CMP: begin
            cmp_a = tm_ff;
            cmp_b = rd_time;
         end
         S_INV_CMP: begin
            cmp_a = nxt_ff;
            cmp_b = prev_ff;
         end
         default: begin
            cmp_a = rd_time;
            cmp_b = tm_ff;
         end
      endcase
   end

   // memory port control
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      rd_addr = idx_ff;
      unique case (state_ff)
         S_SCAN_RD:  rd_addr = idx_ff - IDX_W'(1);
         S_PREV_RD:  rd_addr = pos_ff - IDX_W'(1);
         S_NEXT_RD:  rd_addr = pos_ff;
         S_SHIFT_RD: rd_addr = idx_ff - IDX_W'(1);
         S_RD_RD:    rd_addr = IDX_W'(slot_ff);
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
         end
         S_PLACE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = {nid_ff, tm_ff};
         end
         default: rd_addr = idx_ff;
      endcase
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      nid_in      = nid_ff;
      tm_in       = tm_ff;
      slot_in     = slot_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      nxt_in      = nxt_ff;
      count_in    = count_ff;
      inv_in      = inv_ff;
      res_nid_in  = res_nid_ff;
      res_time_in = res_time_ff;
      status_in   = status_ff;
      fin         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in      = sel_pkg::cmd_type'(cmd);
               nid_in      = neuron_id;
               tm_in       = TIME_BITS'(spike_time);
               slot_in     = slot_index;
               pos_in      = '0;
               res_nid_in  = '0;
               res_time_in = '0;
               status_in   = sel_pkg::ST_OK;
               if (cmd_in == sel_pkg::CMD_READ) begin
                  if (slot_cw < count_cw) begin
                     state_in = S_RD_RD;
                  end else begin
                     status_in = sel_pkg::ST_RANGE;
                     state_in  = S_FIN;
                  end
               end else if (list_full) begin
                  status_in = sel_pkg::ST_FULL;
                  state_in  = S_FIN;
               end else begin
                  case (cmd_in)
                     sel_pkg::CMD_INS_TIME: begin
                        idx_in   = count_idx;
                        state_in = S_SCAN_RD;
                     end
                     sel_pkg::CMD_INS_POS: begin
                        // position past the count becomes an append
                        pos_in   = (slot_cw > count_cw) ? count_idx : IDX_W'(slot_in);
                        state_in = S_PREV_RD;
                     end
                     default: begin
                        pos_in   = count_idx;
                        state_in = S_PREV_RD;
                     end
                  endcase
               end
            end
         end
         // backward scan for the last entry strictly earlier than the new time
         S_SCAN_RD: begin
            if (idx_ff == '0) begin
               pos_in   = '0;
               state_in = S_PREV_RD;
            end else begin
               state_in = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (cmp_lt) begin
               pos_in   = idx_ff;
               state_in = S_PREV_RD;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         // inversion bookkeeping against the neighbors of the slot
         S_PREV_RD: begin
            state_in = (pos_ff == '0) ? S_NEXT_RD : S_PREV_CMP;
         end
         S_PREV_CMP: begin
            prev_in = rd_time;
            if (cmp_lt) begin
               inv_in = inv_ff + IDX_W'(1);
            end
            state_in = S_NEXT_RD;
         end
         S_NEXT_RD: begin
            if (pos_ff == count_idx) begin
               idx_in   = count_idx;
               state_in = S_SHIFT_RD;
            end else begin
               state_in = S_NEXT_CMP;
            end
         end
         S_NEXT_CMP: begin
            nxt_in = rd_time;
            if (cmp_lt) begin
               inv_in = inv_ff + IDX_W'(1);
            end
            if (pos_ff != '0) begin
               state_in = S_INV_CMP;
            end else begin
               idx_in   = count_idx;
               state_in = S_SHIFT_RD;
            end
         end
         S_INV_CMP: begin
            // the old neighbor pair is split by the new entry
            if (cmp_lt) begin
               inv_in = inv_ff - IDX_W'(1);
            end
            idx_in   = count_idx;
            state_in = S_SHIFT_RD;
         end
         // move entries at and above the slot up by one, top first
         S_SHIFT_RD: begin
            state_in = (idx_ff == pos_ff) ? S_PLACE : S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            idx_in   = idx_ff - IDX_W'(1);
            state_in = S_SHIFT_RD;
         end
         S_PLACE: begin
            count_in = count_ff + CNT_W'(1);
            state_in = S_FIN;
         end
         S_RD_RD: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            res_nid_in  = rd_nid;
            res_time_in = rd_time;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (rsp_free) begin
               fin      = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         inv_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         inv_ff   <= inv_in;
      end
   end

   // operands and working values
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      nid_ff      <= nid_in;
      tm_ff       <= tm_in;
      slot_ff     <= slot_in;
      pos_ff      <= pos_in;
      idx_ff      <= idx_in;
      prev_ff     <= prev_in;
      nxt_ff      <= nxt_in;
      res_nid_ff  <= res_nid_in;
      res_time_ff <= res_time_in;
      status_ff   <= status_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign res.fin         = fin;
   assign res.read_neuron = res_nid_ff;
   assign res.read_time   = sel_pkg::TIME_FIELD_W'(res_time_ff);
   assign res.placed_at   = sel_pkg::PLACED_W'(pos_ff);
   assign res.entry_count = sel_pkg::COUNT_FIELD_W'(count_ff);
   assign res.list_sorted = (inv_ff == '0);
   assign res.status      = status_ff;

endmodule

// ----- sv/sorted_event_list.sv -----
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  cmd, neuron_id, spike_time, slot_index
// rsp_      out        rsp_valid/rsp_ready  read_neuron, read_time, placed_at,
//                                           entry_count, list_sorted, status
//
// One request at a time; req_ready is high only while the sequencer is idle.
// A read has read and data states; a rejected request goes straight to finish.
// Appends and inserts check the slot's neighbors and shift entries at and above
// it up by one, top first; time-ordered inserts scan back first. The memory
// makes one registered access per cycle as sequenced.
// Synchronous active-high reset empties the list; no clearing pass is needed.
// A pending response does not block the next request, only its completion.
module sorted_event_list #(
   parameter int CAPACITY  = 256,
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sel_pkg::CMD_W-1:0]             req_cmd,
   input  logic [sel_pkg::NID_W-1:0]             req_neuron_id,
   input  logic [sel_pkg::TIME_FIELD_W-1:0]      req_spike_time,
   input  logic [sel_pkg::SLOT_W-1:0]            req_slot_index,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sel_pkg::NID_W-1:0]             rsp_read_neuron,
   output logic [sel_pkg::TIME_FIELD_W-1:0]      rsp_read_time,
   output logic [sel_pkg::PLACED_W-1:0]          rsp_placed_at,
   output logic [sel_pkg::COUNT_FIELD_W-1:0]     rsp_entry_count,
   output logic                                  rsp_list_sorted,
   output logic [sel_pkg::STATUS_W-1:0]          rsp_status
);

   logic             idle;
   logic             rsp_free;
   sel_pkg::res_type res;
   logic             rsp_valid_ff, rsp_valid_in;
   sel_pkg::res_type rsp_ff, rsp_in;

   sel_ctrl #(
      .CAPACITY  (CAPACITY),
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_valid && req_ready),
      .cmd        (req_cmd),
      .neuron_id  (req_neuron_id),
      .spike_time (req_spike_time),
      .slot_index (req_slot_index),
      .rsp_free   (rsp_free),
      .idle       (idle),
      .res        (res)
   );

   assign req_ready = idle;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res.fin) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_neuron = rsp_ff.read_neuron;
   assign rsp_read_time   = rsp_ff.read_time;
   assign rsp_placed_at   = rsp_ff.placed_at;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_list_sorted = rsp_ff.list_sorted;
   assign rsp_status      = rsp_ff.status;

endmodule

// ----- tb/tb.sv -----
module tb;

   localparam int LIST_DEPTH   = 256;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MAX_REPORTS  = 10;

   // One response, as the block reports it
   typedef struct packed {
      logic [sel_pkg::NID_W-1:0]         read_neuron;
      logic [sel_pkg::TIME_FIELD_W-1:0]  read_time;
      logic [sel_pkg::PLACED_W-1:0]      placed_at;
      logic [sel_pkg::COUNT_FIELD_W-1:0] entry_count;
      logic                              list_sorted;
      sel_pkg::status_type               status;
   } list_result_type;

   // One request; known marks a response written out by hand
   typedef struct packed {
      sel_pkg::cmd_type                  cmd;
      logic [sel_pkg::NID_W-1:0]         neuron_id;
      logic [sel_pkg::TIME_FIELD_W-1:0]  spike_time;
      logic [sel_pkg::SLOT_W-1:0]        slot_index;
      logic                              known;
      list_result_type                   want;
   } list_row_type;

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_ready;
   logic [sel_pkg::CMD_W-1:0]         req_cmd        = sel_pkg::CMD_APPEND;
   logic [sel_pkg::NID_W-1:0]         req_neuron_id  = '0;
   logic [sel_pkg::TIME_FIELD_W-1:0]  req_spike_time = '0;
   logic [sel_pkg::SLOT_W-1:0]        req_slot_index = '0;
   logic                              rsp_valid;
   logic                              rsp_ready      = 1'b0;
   logic [sel_pkg::NID_W-1:0]         rsp_read_neuron;
   logic [sel_pkg::TIME_FIELD_W-1:0]  rsp_read_time;
   logic [sel_pkg::PLACED_W-1:0]      rsp_placed_at;
   logic [sel_pkg::COUNT_FIELD_W-1:0] rsp_entry_count;
   logic                              rsp_list_sorted;
   logic [sel_pkg::STATUS_W-1:0]      rsp_status;

   // Mirror of the event list
   logic [sel_pkg::NID_W-1:0]         mirror_neuron [LIST_DEPTH];
   logic [sel_pkg::TIME_FIELD_W-1:0]  mirror_time [LIST_DEPTH];
   int unsigned                       mirror_count      = 0;
   int unsigned                       mirror_inversions = 0;

   list_result_type          expected_results [$];
   list_row_type             directed_rows [$];
   list_result_type          rsp_got;
   list_result_type          rsp_want;
   int                       mismatch_count = 0;
   int                       send_idle_pct  = 0;
   int                       rsp_stall_pct  = 0;
   int                       quiet_cycles   = 0;

   always #5 clock = ~clock;

   sorted_event_list u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_neuron_id   (req_neuron_id),
      .req_spike_time  (req_spike_time),
      .req_slot_index  (req_slot_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_neuron (rsp_read_neuron),
      .rsp_read_time   (rsp_read_time),
      .rsp_placed_at   (rsp_placed_at),
      .rsp_entry_count (rsp_entry_count),
      .rsp_list_sorted (rsp_list_sorted),
      .rsp_status      (rsp_status)
   );

   // Apply one request to the mirror and return the response it should give
   function automatic list_result_type apply_request(
         input sel_pkg::cmd_type cmd,
         input logic [sel_pkg::NID_W-1:0] nid,
         input logic [sel_pkg::TIME_FIELD_W-1:0] tm,
         input logic [sel_pkg::SLOT_W-1:0] slot);
      list_result_type r;
      int unsigned     pos;
      int unsigned     idx;
      r = '0;
      r.status = sel_pkg::ST_OK;
      if (cmd == sel_pkg::CMD_READ) begin
         if (slot < mirror_count) begin
            r.read_neuron = mirror_neuron[slot];
            r.read_time   = mirror_time[slot];
         end else begin
            r.status = sel_pkg::ST_RANGE;
         end
      end else if (mirror_count >= LIST_DEPTH) begin
         r.status = sel_pkg::ST_FULL;
      end else begin
         case (cmd)
            sel_pkg::CMD_APPEND: begin
               pos = mirror_count;
            end
            sel_pkg::CMD_INS_TIME: begin
               // after the last entry with a strictly smaller time
               pos = 0;
               idx = mirror_count;
               while (idx > 0 && pos == 0) begin
                  if (mirror_time[idx-1] < tm) pos = idx;
                  idx--;
               end
            end
            default: begin
               pos = (slot > mirror_count) ? mirror_count : slot;
            end
         endcase
         // inversion bookkeeping around the new neighbors
         if (pos > 0 && pos < mirror_count && mirror_time[pos] < mirror_time[pos-1])
            mirror_inversions--;
         if (pos > 0 && tm < mirror_time[pos-1])
            mirror_inversions++;
         if (pos < mirror_count && mirror_time[pos] < tm)
            mirror_inversions++;
         for (idx = mirror_count; idx > pos; idx--) begin
            mirror_neuron[idx] = mirror_neuron[idx-1];
            mirror_time[idx]   = mirror_time[idx-1];
         end
         mirror_neuron[pos] = nid;
         mirror_time[pos]   = tm;
         mirror_count++;
         r.placed_at = pos[sel_pkg::PLACED_W-1:0];
      end
      r.entry_count = mirror_count[sel_pkg::COUNT_FIELD_W-1:0];
      r.list_sorted = (mirror_inversions == 0);
      return r;
   endfunction

   function automatic list_result_type make_result(
         input logic [sel_pkg::NID_W-1:0] nid,
         input logic [sel_pkg::TIME_FIELD_W-1:0] tm,
         input int placed, input int count,
         input logic sorted,
         input sel_pkg::status_type st);
      list_result_type r;
      r.read_neuron = nid;
      r.read_time   = tm;
      r.placed_at   = placed[sel_pkg::PLACED_W-1:0];
      r.entry_count = count[sel_pkg::COUNT_FIELD_W-1:0];
      r.list_sorted = sorted;
      r.status      = st;
      return r;
   endfunction

   function automatic string fmt_result(input list_result_type r);
      return $sformatf("nid=%h t=%h at=%0d n=%0d srt=%0d st=%0d", r.read_neuron,
                       r.read_time, r.placed_at, r.entry_count, r.list_sorted, r.status);
   endfunction

   task automatic add_row(input sel_pkg::cmd_type cmd,
                          input logic [sel_pkg::NID_W-1:0] nid,
                          input logic [sel_pkg::TIME_FIELD_W-1:0] tm,
                          input logic [sel_pkg::SLOT_W-1:0] slot,
                          input logic known, input list_result_type want);
      list_row_type row;
      row.cmd        = cmd;
      row.neuron_id  = nid;
      row.spike_time = tm;
      row.slot_index = slot;
      row.known      = known;
      row.want       = want;
      directed_rows.insert(directed_rows.size(), row);
   endtask

   // Present one request, hold it until accepted, then record its expected response
   task automatic drive_request(input list_row_type row);
      list_result_type predicted;
      if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < send_idle_pct);
      end
      req_valid      <= 1'b1;
      req_cmd        <= row.cmd;
      req_neuron_id  <= row.neuron_id;
      req_spike_time <= row.spike_time;
      req_slot_index <= row.slot_index;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_request(row.cmd, row.neuron_id, row.spike_time, row.slot_index);
      expected_results.insert(expected_results.size(), row.known ? row.want : predicted);
   endtask

   // Random requests: reads dominate so the list fills partway through
   task automatic run_phase(input int n_items, input int send_pct, input int stall_pct);
      list_row_type row;
      int           k;
      int           pick;
      int           top;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      for (k = 0; k < n_items; k++) begin
         row  = '0;
         pick = $urandom_range(99, 0);
         row.cmd = (pick < 55) ? sel_pkg::CMD_READ :
                   (pick < 67) ? sel_pkg::CMD_APPEND :
                   (pick < 85) ? sel_pkg::CMD_INS_TIME : sel_pkg::CMD_INS_POS;
         pick = $urandom_range(9, 0);
         row.neuron_id = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom);
         // a narrow set of times makes ties common
         pick = $urandom_range(9, 0);
         if (pick == 0)
            row.spike_time = 32'h0000_0000;
         else if (pick == 1)
            row.spike_time = 32'hFFFF_FFFF;
         else if (pick < 5)
            row.spike_time = $urandom_range(7, 0) << 16;
         else
            row.spike_time = $urandom;
         top  = (mirror_count > 255) ? 255 : mirror_count;
         pick = $urandom_range(99, 0);
         if (row.cmd == sel_pkg::CMD_READ && mirror_count > 0 && pick < 80)
            row.slot_index = 8'($urandom_range(mirror_count - 1, 0));
         else if (row.cmd != sel_pkg::CMD_READ && pick < 70)
            row.slot_index = 8'($urandom_range(top, 0));
         else
            row.slot_index = 8'($urandom_range(255, 0));
         drive_request(row);
      end
   endtask

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t mismatch: %s", $time, what);
   endtask

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_got.read_neuron = rsp_read_neuron;
         rsp_got.read_time   = rsp_read_time;
         rsp_got.placed_at   = rsp_placed_at;
         rsp_got.entry_count = rsp_entry_count;
         rsp_got.list_sorted = rsp_list_sorted;
         rsp_got.status      = sel_pkg::status_type'(rsp_status);
         if (expected_results.size() == 0) begin
            log_mismatch("response with no request outstanding");
         end else begin
            rsp_want = expected_results.pop_front();
            if (rsp_got.read_neuron !== rsp_want.read_neuron ||
                rsp_got.read_time   !== rsp_want.read_time   ||
                rsp_got.placed_at   !== rsp_want.placed_at   ||
                rsp_got.entry_count !== rsp_want.entry_count ||
                rsp_got.list_sorted !== rsp_want.list_sorted ||
                rsp_got.status      !== rsp_want.status)
               log_mismatch($sformatf("exp %s, got %s",
                                      fmt_result(rsp_want), fmt_result(rsp_got)));
         end
      end
   end

   // Watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      // empty list, both read extremes out of range
      add_row(sel_pkg::CMD_READ, 16'h0000, 32'h0, 8'd0, 1'b1,
              make_result(16'h0, 32'h0, 0, 0, 1'b1, sel_pkg::ST_RANGE));
      add_row(sel_pkg::CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 1'b1,
              make_result(16'h0, 32'h0, 0, 0, 1'b1, sel_pkg::ST_RANGE));
      // field extremes; the second append creates an inversion
      add_row(sel_pkg::CMD_APPEND, 16'hFFFF, 32'hFFFF_FFFF, 8'd255, 1'b1,
              make_result(16'h0, 32'h0, 0, 1, 1'b1, sel_pkg::ST_OK));
      add_row(sel_pkg::CMD_APPEND, 16'h0000, 32'h0, 8'd0, 1'b1,
              make_result(16'h0, 32'h0, 1, 2, 1'b0, sel_pkg::ST_OK));
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd0, 1'b1,
              make_result(16'hFFFF, 32'hFFFF_FFFF, 0, 2, 1'b0, sel_pkg::ST_OK));
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd1, 1'b1,
              make_result(16'h0, 32'h0, 0, 2, 1'b0, sel_pkg::ST_OK));
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd2, 1'b1,
              make_result(16'h0, 32'h0, 0, 2, 1'b0, sel_pkg::ST_RANGE));
      // time-ordered inserts, including a tie with an existing time
      add_row(sel_pkg::CMD_INS_TIME, 16'h1234, 32'h0001_8000, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_INS_TIME, 16'h4321, 32'h0, 8'd0, 1'b0, '0);
      // position past the count is clamped to an append
      add_row(sel_pkg::CMD_INS_POS, 16'h00FF, 32'h0002_0000, 8'd255, 1'b0, '0);
      add_row(sel_pkg::CMD_INS_POS, 16'hFF00, 32'h0000_0001, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_INS_POS, 16'h8001, 32'h8000_0000, 8'd2, 1'b0, '0);
      add_row(sel_pkg::CMD_INS_TIME, 16'h7FFF, 32'hFFFF_FFFF, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_APPEND, 16'h5555, 32'hAAAA_AAAA, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_INS_TIME, 16'hAAAA, 32'h5555_5555, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd0, 1'b0, '0);
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd3, 1'b0, '0);
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd7, 1'b0, '0);
      add_row(sel_pkg::CMD_READ, 16'h0, 32'h0, 8'd255, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed_rows.size(); i++) drive_request(directed_rows[i]);

      run_phase(350, 0, 0);
      run_phase(350, 85, 0);
      run_phase(350, 0, 85);
      run_phase(350, 9, 9);
      req_valid <= 1'b0;

      // drain, then watch for stray responses
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
